>>> sv/dfl_pkg.sv
package dfl_pkg;

  localparam int unsigned DEPTH       = 65536;
  localparam int unsigned MAX_BLOCK   = 8192;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned TGT_W       = 32;
  localparam int unsigned BLK_W       = 14;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned BUF_LEN_RST = 65536;

  localparam int unsigned AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEN_W       = $clog2(DEPTH + 1);
  localparam int unsigned EFF_LEN_RST = (BUF_LEN_RST < DEPTH) ? BUF_LEN_RST : DEPTH;
  localparam int unsigned DLY_W       = (LEN_W + FRAC_BITS > TGT_W) ? LEN_W + FRAC_BITS : TGT_W;
  localparam int unsigned BIDX_W      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned BLEN_W      = $clog2(MAX_BLOCK + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(DLY_W + 1);
  localparam int unsigned POS_W       = LEN_W + 1;
  localparam int unsigned Q_W         = POS_W + FRAC_BITS;
  localparam int unsigned PROD_W      = SAMPLE_W + FRAC_BITS + 2;

  typedef struct packed {
    logic              start;
    logic [DLY_W-1:0]  num;
    logic [BLEN_W-1:0] den;
  } dfl_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DLY_W-1:0] quot;
  } dfl_div_rsp_t;

endpackage

>>> sv/dfl_if.sv
interface dfl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dfl_pkg::SAMPLE_W-1:0]  sample;
  logic        [dfl_pkg::TGT_W-1:0]     target_delay;
  logic        [dfl_pkg::BLK_W-1:0]     block_len;

  modport source (output valid, sample, target_delay, block_len, input ready);
  modport sink   (input valid, sample, target_delay, block_len, output ready);
endinterface

interface dfl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dfl_pkg::SAMPLE_W-1:0]  delayed_sample;

  modport source (output valid, delayed_sample, input ready);
  modport sink   (input valid, delayed_sample, output ready);
endinterface

>>> sv/dfl_ram.sv
module dfl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dfl_div.sv
module dfl_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dfl_pkg::dfl_div_req_t req_i,
  output dfl_pkg::dfl_div_rsp_t rsp_o
);

  localparam int unsigned DLY_W  = dfl_pkg::DLY_W;
  localparam int unsigned BLEN_W = dfl_pkg::BLEN_W;
  localparam int unsigned CNT_W  = dfl_pkg::DIV_CNT_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BLEN_W-1:0] rem_q, rem_d;
  logic [DLY_W-1:0]  quo_q, quo_d;
  logic [BLEN_W-1:0] den_q, den_d;
  logic [BLEN_W:0]   trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q, quo_q[DLY_W-1]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DLY_W);
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? BLEN_W'(trial - {1'b0, den_q}) : trial[BLEN_W-1:0];
      quo_d = {quo_q[DLY_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

>>> sv/ramped_fractional_delay_line.sv
// Each item accepted in S_IDLE passes through S_WR, S_RA, S_RB, S_MUL and S_OUT; the first item of
// a block first waits in S_DIV for the bit-serial slope divider. No new item is taken until S_OUT ends;
// the pace is set by the write and two reads of the single-port sample memory plus the interpolation
// multiply; one result may wait in the output register.
// Reset is asynchronous and active low; the sample memory is not cleared, a fill marker
// makes unwritten entries read as zero, and a write of buffer_len restarts the same way.
module ramped_fractional_delay_line (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dfl_pkg::CFG_W-1:0]    cfg_wdata_i,
  dfl_in_if.sink                       in_i,
  dfl_out_if.source                    out_o
);

  localparam int unsigned AW        = dfl_pkg::AW;
  localparam int unsigned LEN_W     = dfl_pkg::LEN_W;
  localparam int unsigned DLY_W     = dfl_pkg::DLY_W;
  localparam int unsigned BIDX_W    = dfl_pkg::BIDX_W;
  localparam int unsigned BLEN_W    = dfl_pkg::BLEN_W;
  localparam int unsigned POS_W     = dfl_pkg::POS_W;
  localparam int unsigned Q_W       = dfl_pkg::Q_W;
  localparam int unsigned PROD_W    = dfl_pkg::PROD_W;
  localparam int unsigned SAMPLE_W  = dfl_pkg::SAMPLE_W;
  localparam int unsigned FRAC_BITS = dfl_pkg::FRAC_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_WR   = 7'b0000100,
    S_RA   = 7'b0001000,
    S_RB   = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_OUT  = 7'b1000000
  } dfl_state_e;

  dfl_state_e                 state_q, state_d;
  logic [AW-1:0]              wp_q, wp_d;
  logic                       wrapped_q, wrapped_d;
  logic [BIDX_W-1:0]          bidx_q, bidx_d;
  logic [BLEN_W-1:0]          blen_q, blen_d;
  logic                       first_q, first_d;
  logic [DLY_W-1:0]           tgt_q, tgt_d;
  logic [DLY_W-1:0]           start_q, start_d;
  logic signed [DLY_W:0]      slope_q, slope_d;
  logic [DLY_W-1:0]           dly_q, dly_d;
  logic [LEN_W-1:0]           eff_len_q, eff_len_d;
  logic                       out_valid_q, out_valid_d;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       neg_q, neg_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic [AW-1:0]              idx1_q, idx1_d;
  logic [FRAC_BITS-1:0]       frac_q, frac_d;
  logic signed [SAMPLE_W-1:0] a_q, a_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [SAMPLE_W-1:0] out_sample_q, out_sample_d;

  logic                       in_acc;
  logic                       blk_start;
  logic [BLEN_W-1:0]          n_c;
  logic [DLY_W-1:0]           lim_c;
  logic [DLY_W-1:0]           tgt_in;
  logic [DLY_W-1:0]           tgt_c;
  logic [DLY_W-1:0]           start_c;
  logic signed [DLY_W:0]      diff_c;
  logic [DLY_W-1:0]           mag_c;
  logic [POS_W-1:0]           pos_c;
  logic [Q_W-1:0]             q_c;
  logic [POS_W-1:0]           iq_c;
  logic [POS_W-1:0]           idx_c;
  logic [LEN_W-1:0]           idx1_c;
  logic [LEN_W-1:0]           wnext_c;
  logic [BLEN_W-1:0]          bnext_c;
  logic signed [DLY_W:0]      dsum_c;
  logic signed [SAMPLE_W-1:0] rdata_s;
  logic signed [SAMPLE_W-1:0] b_c;
  logic signed [SAMPLE_W:0]   dab_c;
  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [PROD_W-1:0]   mul_c;
  logic signed [PROD_W-1:0]   sum_c;
  logic                       out_ok;
  logic                       ok_a, ok_b;
  logic [LEN_W-1:0]           cfg_len_c;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [SAMPLE_W-1:0]        ram_rdata;

  dfl_pkg::dfl_div_req_t      div_req;
  dfl_pkg::dfl_div_rsp_t      div_rsp;

  dfl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (dfl_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_q),
    .rdata_o (ram_rdata)
  );

  dfl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign in_acc               = in_i.valid && in_i.ready;
  assign blk_start            = (bidx_q == '0);
  assign out_o.valid          = out_valid_q;
  assign out_o.delayed_sample = out_sample_q;
  assign out_ok               = !out_valid_q || out_o.ready;

  always_comb begin
    if (in_i.block_len == '0) begin
      n_c = BLEN_W'(1);
    end else if (32'(in_i.block_len) > 32'(dfl_pkg::MAX_BLOCK)) begin
      n_c = BLEN_W'(dfl_pkg::MAX_BLOCK);
    end else begin
      n_c = BLEN_W'(in_i.block_len);
    end
    lim_c   = DLY_W'(eff_len_q) << FRAC_BITS;
    tgt_in  = DLY_W'(in_i.target_delay);
    tgt_c   = (tgt_in > lim_c) ? lim_c : tgt_in;
    start_c = first_q ? tgt_c : tgt_q;
    diff_c  = $signed({1'b0, tgt_c}) - $signed({1'b0, start_c});
    mag_c   = diff_c[DLY_W] ? DLY_W'(-diff_c) : diff_c[DLY_W-1:0];

    if (32'(cfg_wdata_i) < 32'd2) begin
      cfg_len_c = LEN_W'(2);
    end else if (32'(cfg_wdata_i) > 32'(dfl_pkg::DEPTH)) begin
      cfg_len_c = LEN_W'(dfl_pkg::DEPTH);
    end else begin
      cfg_len_c = LEN_W'(cfg_wdata_i);
    end

    // Biased by one full ring so the read position never goes negative.
    pos_c  = POS_W'(wp_q) + POS_W'(eff_len_q);
    q_c    = {pos_c, {FRAC_BITS{1'b0}}} - Q_W'(dly_q);
    iq_c   = q_c[Q_W-1:FRAC_BITS];
    idx_c  = (iq_c >= POS_W'(eff_len_q)) ? iq_c - POS_W'(eff_len_q) : iq_c;
    idx1_c = LEN_W'(idx_q) + LEN_W'(1);
    if (idx1_c >= eff_len_q) begin
      idx1_c = '0;
    end

    // Entries beyond the fill mark have not been written since the last clear.
    ok_a    = wrapped_q || (idx_q <= wp_q);
    ok_b    = wrapped_q || (idx1_q <= wp_q);
    rdata_s = $signed(ram_rdata);
    b_c     = ok_b ? rdata_s : '0;
    dab_c   = $signed({b_c[SAMPLE_W-1], b_c}) - $signed({a_q[SAMPLE_W-1], a_q});
    frac_s  = $signed({1'b0, frac_q});
    mul_c   = dab_c * frac_s;
    sum_c   = PROD_W'(a_q) + (prod_q >>> FRAC_BITS);

    wnext_c = LEN_W'(wp_q) + LEN_W'(1);
    bnext_c = BLEN_W'(bidx_q) + BLEN_W'(1);
    dsum_c  = $signed({1'b0, dly_q}) + slope_q;
  end

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    wrapped_d    = wrapped_q;
    bidx_d       = bidx_q;
    blen_d       = blen_q;
    first_d      = first_q;
    tgt_d        = tgt_q;
    start_d      = start_q;
    slope_d      = slope_q;
    dly_d        = dly_q;
    eff_len_d    = eff_len_q;
    out_valid_d  = out_valid_q;
    sample_d     = sample_q;
    neg_d        = neg_q;
    idx_d        = idx_q;
    idx1_d       = idx1_q;
    frac_d       = frac_q;
    a_d          = a_q;
    prod_d       = prod_q;
    out_sample_d = out_sample_q;
    ram_we       = 1'b0;
    ram_addr     = idx_q;
    div_req.start = in_acc && blk_start;
    div_req.num   = mag_c;
    div_req.den   = n_c;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d = in_i.sample;
          if (blk_start) begin
            tgt_d   = tgt_c;
            start_d = start_c;
            first_d = 1'b0;
            blen_d  = n_c;
            neg_d   = diff_c[DLY_W];
            state_d = S_DIV;
          end else begin
            state_d = S_WR;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          slope_d = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
          dly_d   = start_q;
          state_d = S_WR;
        end
      end
      S_WR: begin
        ram_we   = 1'b1;
        ram_addr = wp_q;
        idx_d    = AW'(idx_c);
        frac_d   = q_c[FRAC_BITS-1:0];
        state_d  = S_RA;
      end
      S_RA: begin
        ram_addr = idx_q;
        idx1_d   = AW'(idx1_c);
        state_d  = S_RB;
      end
      S_RB: begin
        ram_addr = idx1_q;
        a_d      = ok_a ? rdata_s : '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        prod_d  = mul_c + (PROD_W'(1) <<< (FRAC_BITS - 1));
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ok) begin
          out_valid_d  = 1'b1;
          out_sample_d = sum_c[SAMPLE_W-1:0];
          if (wnext_c >= eff_len_q) begin
            wp_d      = '0;
            wrapped_d = 1'b1;
          end else begin
            wp_d = AW'(wnext_c);
          end
          bidx_d  = (bnext_c >= blen_q) ? '0 : BIDX_W'(bnext_c);
          dly_d   = dsum_c[DLY_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      eff_len_d = cfg_len_c;
      wp_d      = '0;
      wrapped_d = 1'b0;
      bidx_d    = '0;
      blen_d    = BLEN_W'(1);
      first_d   = 1'b1;
      tgt_d     = '0;
      start_d   = '0;
      slope_d   = '0;
      dly_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      bidx_q      <= '0;
      blen_q      <= BLEN_W'(1);
      first_q     <= 1'b1;
      tgt_q       <= '0;
      start_q     <= '0;
      slope_q     <= '0;
      dly_q       <= '0;
      eff_len_q   <= LEN_W'(dfl_pkg::EFF_LEN_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      bidx_q      <= bidx_d;
      blen_q      <= blen_d;
      first_q     <= first_d;
      tgt_q       <= tgt_d;
      start_q     <= start_d;
      slope_q     <= slope_d;
      dly_q       <= dly_d;
      eff_len_q   <= eff_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    neg_q        <= neg_d;
    idx_q        <= idx_d;
    idx1_q       <= idx1_d;
    frac_q       <= frac_d;
    a_q          <= a_d;
    prod_q       <= prod_d;
    out_sample_q <= out_sample_d;
  end

  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(wp_q) < eff_len_q)
    else $error("Write position lies outside the active ring.");

  a_bidx_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BLEN_W'(bidx_q) < blen_q)
    else $error("Block index reached the block length.");

  a_div_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && div_rsp.done && !cfg_we_i |=> (state_q == S_WR))
    else $error("Slope division finished but the sample write did not follow.");

  a_read_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RB) |-> (LEN_W'(idx_q) < eff_len_q) && (LEN_W'(idx1_q) < eff_len_q))
    else $error("Interpolation read address lies outside the active ring.");

endmodule
